// File: rtl/accel_crash_rollover_detector_unit_defines.svh
// assertion helpers shared by the checker
`ifndef ACCEL_CRASH_ROLLOVER_DETECTOR_UNIT_DEFINES_SVH
`define ACCEL_CRASH_ROLLOVER_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define ACRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/acrd_pkg.sv
`timescale 1ns / 1ps
package acrd_pkg;
	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int ACCEL_W = 16;
	localparam int DIFF_W = 17;
	localparam int SPEED_W = 12;
	localparam int MAG_W = 21;
	localparam int ANGLE_W = 16;
	localparam int THR_W = 17;
	localparam int LIM_W = 8;
	localparam int HOLD_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam int SQ_W = 32;
	localparam int SUMD_W = 34;
	localparam int SUMA_W = 32;
	localparam int RAD_W = 48;
	localparam int ROOT_W = 24;
	localparam int REM_W = 26;
	localparam int ROOT_CNT_W = 5;
	localparam int CORDIC_STEPS = 18;
	localparam int CORDIC_W = 28;
	localparam int ZACC_W = 26;
	localparam int ATAN_W = 23;
	localparam int STEP_W = 5;
	localparam int FIFO_DEPTH = 2;
	localparam int ANOMALY_RATIO = 3;

	localparam logic [THR_W-1:0] THR_RESET = '0;
	localparam logic [LIM_W-1:0] LIM_RESET = 8'd45;
	localparam logic [HOLD_W-1:0] RELOAD_RESET = 8'd75;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd2;
	localparam logic [SPEED_W-1:0] SPEED_VETO = 12'd500;
	localparam logic signed [ANGLE_W:0] ANGLE_MAX = 17'sd23040;
	localparam logic signed [ZACC_W-1:0] ANGLE_ROUND = 26'sd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD  = 2'd0,
		CFG_ROLL_LIMIT = 2'd1,
		CFG_HOLDOFF    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [THR_W-1:0]  threshold;
		logic [LIM_W-1:0]  roll_limit;
		logic [HOLD_W-1:0] reload;
	} acrd_cfg_t;

	typedef struct packed {
		logic [DIFF_W-1:0]  dx;
		logic [DIFF_W-1:0]  dy;
		logic [DIFF_W-1:0]  dz;
		logic [ACCEL_W-1:0] ax;
		logic [ACCEL_W-1:0] ay;
		logic [ACCEL_W-1:0] az;
		logic [SPEED_W-1:0] speed;
	} acrd_job_t;

	typedef struct packed {
		logic               evaluated;
		logic               impact;
		logic [MAG_W-1:0]   magnitude;
		logic [ANGLE_W-1:0] roll;
		logic [ANGLE_W-1:0] pitch;
		logic               rollover;
	} acrd_result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQUARE,
		BK_ROOT_GO,
		BK_ROOT,
		BK_ROT_GO,
		BK_ROTATE,
		BK_DONE
	} bk_state_t;

	// arctangent of 2^-i in degrees, 16 fraction bits
	function automatic logic [ATAN_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
		logic [ATAN_W-1:0] r;
		unique case (i)
			5'd0:    r = 23'd2949120;
			5'd1:    r = 23'd1740967;
			5'd2:    r = 23'd919879;
			5'd3:    r = 23'd466945;
			5'd4:    r = 23'd234379;
			5'd5:    r = 23'd117304;
			5'd6:    r = 23'd58666;
			5'd7:    r = 23'd29335;
			5'd8:    r = 23'd14668;
			5'd9:    r = 23'd7334;
			5'd10:   r = 23'd3667;
			5'd11:   r = 23'd1833;
			5'd12:   r = 23'd917;
			5'd13:   r = 23'd458;
			5'd14:   r = 23'd229;
			5'd15:   r = 23'd115;
			5'd16:   r = 23'd57;
			5'd17:   r = 23'd29;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// File: rtl/acrd_fifo.sv
`timescale 1ns / 1ps
module acrd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  acrd_pkg::acrd_job_t push_job,
	output logic              full,
	input  logic              pop,
	output acrd_pkg::acrd_job_t pop_job,
	output logic              empty
);
	import acrd_pkg::*;

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	acrd_job_t        mem_q [FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign full    = (cnt_q == (PW+1)'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// File: rtl/acrd_front.sv
`timescale 1ns / 1ps
module acrd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [acrd_pkg::ACCEL_W-1:0] accel_x,
	input  logic [acrd_pkg::ACCEL_W-1:0] accel_y,
	input  logic [acrd_pkg::ACCEL_W-1:0] accel_z,
	input  logic [acrd_pkg::SPEED_W-1:0] speed_tenths_kmph,
	input  logic                         q_full,
	output logic                         push,
	output acrd_pkg::acrd_job_t          push_job
);
	import acrd_pkg::*;

	logic [ACCEL_W-1:0] prev_x_q, prev_y_q, prev_z_q;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// per-axis difference to the previous sample
	always_comb begin
		push_job.dx    = {accel_x[ACCEL_W-1], accel_x} - {prev_x_q[ACCEL_W-1], prev_x_q};
		push_job.dy    = {accel_y[ACCEL_W-1], accel_y} - {prev_y_q[ACCEL_W-1], prev_y_q};
		push_job.dz    = {accel_z[ACCEL_W-1], accel_z} - {prev_z_q[ACCEL_W-1], prev_z_q};
		push_job.ax    = accel_x;
		push_job.ay    = accel_y;
		push_job.az    = accel_z;
		push_job.speed = speed_tenths_kmph;
	end

	// previous sample, updated on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
		end else if (push) begin
			prev_x_q <= accel_x;
			prev_y_q <= accel_y;
			prev_z_q <= accel_z;
		end
	end
endmodule

// File: rtl/acrd_sqrt.sv
`timescale 1ns / 1ps
module acrd_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [acrd_pkg::RAD_W-1:0]  radicand,
	output logic                        done,
	output logic [acrd_pkg::ROOT_W-1:0] root
);
	import acrd_pkg::*;

	logic [RAD_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic                  busy_q, done_q;
	logic [REM_W+1:0]      rem_sh, trial, rem_nx;
	logic                  ge;

	assign root = root_q;
	assign done = done_q;

	// one result bit per cycle
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = (rem_sh >= trial);
		rem_nx = ge ? (rem_sh - trial) : rem_sh;
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= rem_nx[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == ROOT_CNT_W'(ROOT_W-1));
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ROOT_CNT_W'(ROOT_W-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule

// File: rtl/acrd_cordic.sv
`timescale 1ns / 1ps
module acrd_cordic (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [acrd_pkg::ROOT_W-1:0]  x0,
	input  logic [acrd_pkg::DIFF_W-1:0]  num,
	output logic                         done,
	output logic [acrd_pkg::ANGLE_W-1:0] angle
);
	import acrd_pkg::*;

	logic signed [CORDIC_W-1:0] x_q, y_q, xs, ys;
	logic signed [ZACC_W-1:0]   z_q, step_ang, z_rnd;
	logic signed [ANGLE_W:0]    a_full;
	logic [STEP_W-1:0]          i_q;
	logic                       busy_q, done_q;

	assign done = done_q;

	// shifted operands and table angle for this step
	always_comb begin
		xs       = x_q >>> i_q;
		ys       = y_q >>> i_q;
		step_ang = $signed({{(ZACC_W-ATAN_W){1'b0}}, atan_deg(i_q)});
	end

	// round to 7 fraction bits and clamp
	always_comb begin
		z_rnd  = z_q + ANGLE_ROUND;
		a_full = z_rnd[ZACC_W-1:9];
		if (a_full > ANGLE_MAX) begin
			angle = ANGLE_MAX[ANGLE_W-1:0];
		end else if (a_full < -ANGLE_MAX) begin
			angle = ANGLE_W'(-ANGLE_MAX);
		end else begin
			angle = a_full[ANGLE_W-1:0];
		end
	end

	// vectoring rotations
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= $signed({{(CORDIC_W-ROOT_W){1'b0}}, x0});
			y_q <= $signed({{(CORDIC_W-DIFF_W-8){num[DIFF_W-1]}}, num, 8'd0});
			z_q <= '0;
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_ang;
			end
		end
	end

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (i_q == STEP_W'(CORDIC_STEPS-1));
			if (start) begin
				i_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == STEP_W'(CORDIC_STEPS-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule

// File: rtl/acrd_back.sv
`timescale 1ns / 1ps
module acrd_back #(
	parameter int HISTORY_DEPTH = acrd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  acrd_pkg::acrd_cfg_t   cfg,
	input  logic                  q_empty,
	output logic                  pop,
	input  acrd_pkg::acrd_job_t   job,
	output logic                  out_valid,
	input  logic                  out_stall,
	output acrd_pkg::acrd_result_t result
);
	import acrd_pkg::*;

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_W = MAG_W + $clog2(HISTORY_DEPTH);
	localparam int CMP_W = SUM_W + 2;

	bk_state_t state_q, state_d;

	acrd_job_t          job_q;
	logic               skip_q;
	logic [2:0]         cnt_q;
	logic [SQ_W-1:0]    prod_s1;
	logic [SUMD_W-1:0]  sumd_q;
	logic [SUMA_W-1:0]  sumr_q, sump_q;
	logic [HOLD_W-1:0]  hold_q, hold_dec;
	logic [MAG_W-1:0]   mag_q;
	logic [ANGLE_W-1:0] roll_q, pitch_q;

	logic [MAG_W-1:0]   ring_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] ring_vld_q;
	logic [MAG_W-1:0]   rd_data_q;
	logic               rd_vld_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [SUM_W-1:0]   sum_q;
	logic [MAG_W-1:0]   old_mag;

	logic               out_valid_q;
	acrd_result_t       res_q, res_d;

	logic               sqrt_start, cordic_start, load_out, out_free;
	logic               mag_done, roll_sq_done, pitch_sq_done, roll_done, pitch_done;
	logic               root_done, rot_done;
	logic [ROOT_W-1:0]  mag_root, roll_root, pitch_root;
	logic [ANGLE_W-1:0] roll_ang, pitch_ang;

	logic signed [DIFF_W-1:0]   sq_op;
	logic signed [2*DIFF_W-1:0] sq_prod;
	logic               high_g, anomaly, impact;
	logic [CMP_W-1:0]   mag_scaled, sum_scaled;
	logic [ANGLE_W-1:0] abs_roll, abs_pitch;
	logic [ANGLE_W-1:0] lim_q7;
	logic [DIFF_W-1:0]  pitch_num;

	assign out_valid = out_valid_q;
	assign result    = res_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign hold_dec  = (hold_q != '0) ? hold_q - 1'b1 : '0;
	assign pitch_num = -{job_q.ax[ACCEL_W-1], job_q.ax};

	// all three roots finish together, both angles too
	assign root_done = mag_done && roll_sq_done && pitch_sq_done;
	assign rot_done  = roll_done && pitch_done;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = (hold_dec != '0) ? BK_DONE : BK_SQUARE;
				end
			end
			BK_SQUARE: begin
				if (cnt_q == 3'd6) begin
					state_d = BK_ROOT_GO;
				end
			end
			BK_ROOT_GO: state_d = BK_ROOT;
			BK_ROOT: begin
				if (root_done) begin
					state_d = BK_ROT_GO;
				end
			end
			BK_ROT_GO: state_d = BK_ROTATE;
			BK_ROTATE: begin
				if (rot_done) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop          = (state_q == BK_IDLE) && !q_empty;
		sqrt_start   = (state_q == BK_ROOT_GO);
		cordic_start = (state_q == BK_ROT_GO);
		load_out     = (state_q == BK_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// shared squarer
	always_comb begin
		unique case (cnt_q)
			3'd0:    sq_op = $signed(job_q.dx);
			3'd1:    sq_op = $signed(job_q.dy);
			3'd2:    sq_op = $signed(job_q.dz);
			3'd3:    sq_op = $signed({job_q.ax[ACCEL_W-1], job_q.ax});
			3'd4:    sq_op = $signed({job_q.ay[ACCEL_W-1], job_q.ay});
			3'd5:    sq_op = $signed({job_q.az[ACCEL_W-1], job_q.az});
			default: sq_op = '0;
		endcase
		sq_prod = sq_op * sq_op;
	end

	// job capture, square accumulation, captured results
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= job;
			sumd_q <= '0;
			sumr_q <= '0;
			sump_q <= '0;
		end
		prod_s1 <= sq_prod[SQ_W-1:0];
		if (state_q == BK_SQUARE && cnt_q != 3'd0) begin
			unique case (cnt_q)
				3'd1, 3'd2, 3'd3: sumd_q <= sumd_q + SUMD_W'(prod_s1);
				3'd4: sumr_q <= sumr_q + prod_s1;
				3'd5: sump_q <= sump_q + prod_s1;
				3'd6: begin
					sumr_q <= sumr_q + prod_s1;
					sump_q <= sump_q + prod_s1;
				end
				default: sumd_q <= sumd_q;
			endcase
		end
		if (state_q == BK_ROOT && root_done) begin
			mag_q <= mag_root[MAG_W-1:0];
		end
		if (state_q == BK_ROTATE && rot_done) begin
			roll_q  <= (job_q.ay == '0) ? '0 : roll_ang;
			pitch_q <= (job_q.ax == '0) ? '0 : pitch_ang;
		end
		if (load_out) begin
			res_q <= res_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			skip_q      <= 1'b0;
			hold_q      <= HOLD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q  <= '0;
				skip_q <= (hold_dec != '0);
				hold_q <= hold_dec;
			end else if (state_q == BK_SQUARE) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out && !skip_q && impact) begin
				hold_q <= cfg.reload;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// magnitude ring, read every cycle at the write pointer
	always_ff @(posedge clk) begin
		rd_data_q <= ring_mem[ptr_q];
		if (cordic_start) begin
			ring_mem[ptr_q] <= mag_q;
		end
	end

	assign old_mag = rd_vld_q ? rd_data_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			rd_vld_q   <= 1'b0;
			ptr_q      <= '0;
			sum_q      <= '0;
		end else begin
			rd_vld_q <= ring_vld_q[ptr_q];
			if (cordic_start) begin
				ring_vld_q[ptr_q] <= 1'b1;
				sum_q <= sum_q - SUM_W'(old_mag) + SUM_W'(mag_q);
				ptr_q <= (ptr_q == PTR_W'(HISTORY_DEPTH-1)) ? '0 : ptr_q + 1'b1;
			end
		end
	end

	// impact and rollover decision
	always_comb begin
		mag_scaled = CMP_W'(mag_q) * CMP_W'(HISTORY_DEPTH);
		sum_scaled = CMP_W'(sum_q) * CMP_W'(ANOMALY_RATIO);
		high_g     = (mag_q >= {cfg.threshold, 4'd0});
		anomaly    = (mag_scaled > sum_scaled);
		impact     = high_g && anomaly && (job_q.speed <= SPEED_VETO);
		abs_roll   = roll_q[ANGLE_W-1] ? -roll_q : roll_q;
		abs_pitch  = pitch_q[ANGLE_W-1] ? -pitch_q : pitch_q;
		lim_q7     = {1'b0, cfg.roll_limit, 7'd0};
		if (skip_q) begin
			res_d = '0;
		end else begin
			res_d.evaluated = 1'b1;
			res_d.impact    = impact;
			res_d.magnitude = impact ? mag_q : '0;
			res_d.roll      = roll_q;
			res_d.pitch     = pitch_q;
			res_d.rollover  = (abs_roll > lim_q7) || (abs_pitch > lim_q7);
		end
	end

	// root units run side by side
	acrd_sqrt u_sqrt_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({6'd0, sumd_q, 8'd0}),
		.done     (mag_done),
		.root     (mag_root)
	);

	acrd_sqrt u_sqrt_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({sumr_q, 16'd0}),
		.done     (roll_sq_done),
		.root     (roll_root)
	);

	acrd_sqrt u_sqrt_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({sump_q, 16'd0}),
		.done     (pitch_sq_done),
		.root     (pitch_root)
	);

	// angle units, roll and pitch in parallel
	acrd_cordic u_cordic_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x0     (roll_root),
		.num    ({job_q.ay[ACCEL_W-1], job_q.ay}),
		.done   (roll_done),
		.angle  (roll_ang)
	);

	acrd_cordic u_cordic_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x0     (pitch_root),
		.num    (pitch_num),
		.done   (pitch_done),
		.angle  (pitch_ang)
	);
endmodule

// File: rtl/accel_crash_rollover_detector_unit.sv
`timescale 1ns / 1ps
// Impact and rollover detector for a three-axis accelerometer.
// Input channel: in_valid / in_stall with accel_x, accel_y, accel_z and
// speed_tenths_kmph; a sample transfers when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with one result per sample, in order.
// Configuration: write cfg_data to register cfg_index while cfg_we is high
// (0 impact threshold, 1 rollover limit, 2 hold-off reload); only when idle.
// A front stage takes samples, forms the differences to the previous sample
// and queues them two deep; the back stage works on one sample at a time.
// An evaluated sample passes through squaring on one shared multiplier,
// the bit-serial square root units, the CORDIC iterations and the
// hand-off states. A sample swallowed by hold-off skips straight to the
// result. The back stage pops the next sample only after the last result
// has been loaded into the output register.
// Reset clears the previous sample, the magnitude history and the ring sum,
// sets the hold-off count to 2 and the registers to their defaults.
// While out_stall is high the result holds; the back stage may finish the
// next sample meanwhile, then the queue fills and in_stall rises.
module accel_crash_rollover_detector_unit #(
	parameter int HISTORY_DEPTH = acrd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [acrd_pkg::ACCEL_W-1:0]    accel_x,
	input  logic [acrd_pkg::ACCEL_W-1:0]    accel_y,
	input  logic [acrd_pkg::ACCEL_W-1:0]    accel_z,
	input  logic [acrd_pkg::SPEED_W-1:0]    speed_tenths_kmph,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            evaluated,
	output logic                            crash_hit,
	output logic [acrd_pkg::MAG_W-1:0]      crash_mag,
	output logic [acrd_pkg::ANGLE_W-1:0]    roll_deg,
	output logic [acrd_pkg::ANGLE_W-1:0]    pitch_deg,
	output logic                            flip_hit,
	input  logic                            cfg_we,
	input  logic [acrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acrd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import acrd_pkg::*;

	acrd_cfg_t    cfg_q;
	acrd_job_t    push_job, pop_job;
	acrd_result_t result;
	logic         push, pop, q_full, q_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THR_RESET;
			cfg_q.roll_limit <= LIM_RESET;
			cfg_q.reload     <= RELOAD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_THRESHOLD:  cfg_q.threshold  <= cfg_data;
				CFG_ROLL_LIMIT: cfg_q.roll_limit <= cfg_data[LIM_W-1:0];
				CFG_HOLDOFF:    cfg_q.reload     <= cfg_data[HOLD_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	acrd_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.accel_x           (accel_x),
		.accel_y           (accel_y),
		.accel_z           (accel_z),
		.speed_tenths_kmph (speed_tenths_kmph),
		.q_full            (q_full),
		.push              (push),
		.push_job          (push_job)
	);

	acrd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	acrd_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.pop       (pop),
		.job       (pop_job),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign evaluated = result.evaluated;
	assign crash_hit = result.impact;
	assign crash_mag = result.magnitude;
	assign roll_deg  = result.roll;
	assign pitch_deg = result.pitch;
	assign flip_hit  = result.rollover;
endmodule

// File: rtl/acrd_checker.sv
`timescale 1ns / 1ps
`include "accel_crash_rollover_detector_unit_defines.svh"
module acrd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         evaluated,
	input logic                         crash_hit,
	input logic [acrd_pkg::MAG_W-1:0]   crash_mag,
	input logic [acrd_pkg::ANGLE_W-1:0] roll_deg,
	input logic [acrd_pkg::ANGLE_W-1:0] pitch_deg,
	input logic                         flip_hit
);
	import acrd_pkg::*;

	// a stalled result stays offered
	`ACRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

	// swallowed samples carry an all-zero result
	`ACRD_ASSERT_NOW(a_skip_zero, out_valid && !evaluated, !crash_hit && crash_mag == '0 && roll_deg == '0 && pitch_deg == '0 && !flip_hit, "skipped sample not zero")

	// magnitude only reported with an impact
	`ACRD_ASSERT_NOW(a_mag_impact, out_valid && !crash_hit, crash_mag == '0, "magnitude without impact")

	// angles stay within plus or minus 180 degrees
	`ACRD_ASSERT_NOW(a_angle_range, out_valid, $signed(roll_deg) <= ANGLE_MAX && $signed(roll_deg) >= -ANGLE_MAX && $signed(pitch_deg) <= ANGLE_MAX && $signed(pitch_deg) >= -ANGLE_MAX, "angle out of range")
endmodule

bind accel_crash_rollover_detector_unit acrd_checker u_acrd_checker (.*);

// File: tb/sv/accel_crash_rollover_detector_unit_tb.sv
`timescale 1ns / 1ps
module accel_crash_rollover_detector_unit_tb;
	import acrd_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RING_LEN = 8;
	localparam int LIMIT_CYCLES = 2000000;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 2'd3;
	localparam longint ATAN_Q16 [18] = '{2949120, 1740967, 919879, 466945, 234379,
		117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

	typedef struct {
		logic [ACCEL_W-1:0] x;
		logic [ACCEL_W-1:0] y;
		logic [ACCEL_W-1:0] z;
		logic [SPEED_W-1:0] speed;
	} sample_t;

	typedef struct {
		logic               evaluated;
		logic               impact;
		logic [MAG_W-1:0]   magnitude;
		logic [ANGLE_W-1:0] roll;
		logic [ANGLE_W-1:0] pitch;
		logic               rollover;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [ACCEL_W-1:0] accel_x, accel_y, accel_z;
	logic [SPEED_W-1:0] speed_tenths_kmph;
	logic out_valid;
	logic out_stall = 1'b0;
	logic evaluated, crash_hit, flip_hit;
	logic [MAG_W-1:0] crash_mag;
	logic [ANGLE_W-1:0] roll_deg, pitch_deg;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// detector shadow state
	longint unsigned thr_q, lim_q, reload_q;
	longint last_x, last_y, last_z;
	longint unsigned holdoff_q;
	longint unsigned mag_hist [RING_LEN];
	int unsigned hist_ptr;
	longint unsigned hist_sum;

	verdict_t pending_verdicts [$];
	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int samples_sent;
	int verdicts_seen;
	int impacts_seen;
	int rollovers_seen;
	int swallowed_seen;
	longint cycle_cnt = 0;

	accel_crash_rollover_detector_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.speed_tenths_kmph(speed_tenths_kmph),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.evaluated(evaluated),
		.crash_hit(crash_hit),
		.crash_mag(crash_mag),
		.roll_deg(roll_deg),
		.pitch_deg(pitch_deg),
		.flip_hit(flip_hit),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#(CLK_HALF);
		clk = 1'b0;
		#(CLK_HALF);
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("[accel_crash_rollover_detector_unit] ERROR");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// atan2(num, sqrt(sq)) in degrees with 7 fraction bits
	function automatic longint tilt_q7(longint num, longint unsigned sq);
		longint xa, ya, za, xs, ys, a;
		xa = longint'(int_sqrt(sq << 16));
		ya = num * 256;
		za = 0;
		if (num == 0)
			return 0;
		for (int i = 0; i < 18; i++) begin
			xs = xa >>> i;
			ys = ya >>> i;
			if (ya > 0) begin
				xa += ys;
				ya -= xs;
				za += ATAN_Q16[i];
			end else begin
				xa -= ys;
				ya += xs;
				za -= ATAN_Q16[i];
			end
		end
		a = (za + 256) >>> 9;
		if (a > 23040)
			a = 23040;
		if (a < -23040)
			a = -23040;
		return a;
	endfunction

	// expected verdict for one sample; advances the shadow state
	function automatic verdict_t judge_sample(sample_t s);
		verdict_t v;
		longint ax, ay, az, dx, dy, dz, roll, pitch, lim;
		longint unsigned mag;
		logic high_g, anomaly, hit;
		ax = longint'($signed(s.x));
		ay = longint'($signed(s.y));
		az = longint'($signed(s.z));
		dx = ax - last_x;
		dy = ay - last_y;
		dz = az - last_z;
		last_x = ax;
		last_y = ay;
		last_z = az;
		v = '{1'b0, 1'b0, '0, '0, '0, 1'b0};
		if (holdoff_q > 0)
			holdoff_q--;
		if (holdoff_q > 0)
			return v;
		mag = int_sqrt(longint'(dx * dx + dy * dy + dz * dz) << 8) & 64'h1FFFFF;
		hist_sum = hist_sum - mag_hist[hist_ptr] + mag;
		mag_hist[hist_ptr] = mag;
		hist_ptr = (hist_ptr + 1) % RING_LEN;
		high_g = mag >= thr_q * 16;
		anomaly = mag * RING_LEN > 3 * hist_sum;
		hit = high_g && anomaly && s.speed <= 500;
		if (hit)
			holdoff_q = reload_q;
		roll = tilt_q7(ay, ax * ax + az * az);
		pitch = tilt_q7(-ax, ay * ay + az * az);
		lim = longint'(lim_q) * 128;
		v.evaluated = 1'b1;
		v.impact = hit;
		v.magnitude = hit ? mag[MAG_W-1:0] : '0;
		v.roll = roll[ANGLE_W-1:0];
		v.pitch = pitch[ANGLE_W-1:0];
		v.rollover = (roll > lim) || (-roll > lim) || (pitch > lim) || (-pitch > lim);
		return v;
	endfunction

	// one input transfer; called at a falling edge, returns at a falling edge
	task automatic send_sample(sample_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= s.x;
		accel_y <= s.y;
		accel_z <= s.z;
		speed_tenths_kmph <= s.speed;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_verdicts.push_back(judge_sample(s));
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// register write while the detector is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
			CFG_THRESHOLD:  thr_q = val & 64'h1FFFF;
			CFG_ROLL_LIMIT: lim_q = val & 64'hFF;
			CFG_HOLDOFF:    reload_q = val & 64'hFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic sample_t make_sample(int unsigned x, int unsigned y, int unsigned z,
			int unsigned sp);
		sample_t s;
		s.x = x[ACCEL_W-1:0];
		s.y = y[ACCEL_W-1:0];
		s.z = z[ACCEL_W-1:0];
		s.speed = sp[SPEED_W-1:0];
		return s;
	endfunction

	// random sample: calm driving with jitter most often, some crashes and tilts
	function automatic sample_t random_sample();
		int unsigned pick;
		int jx, jy, jz;
		int unsigned sp;
		pick = $urandom_range(99);
		sp = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(520);
		if (pick < 45) begin
			jx = int'(last_x) + int'($urandom_range(64)) - 32;
			jy = int'(last_y) + int'($urandom_range(64)) - 32;
			jz = int'(last_z) + int'($urandom_range(64)) - 32;
			if (jx > 32767) jx = 32767;
			if (jx < -32768) jx = -32768;
			if (jy > 32767) jy = 32767;
			if (jy < -32768) jy = -32768;
			if (jz > 32767) jz = 32767;
			if (jz < -32768) jz = -32768;
			return make_sample(jx, jy, jz, sp);
		end
		if (pick < 70)
			return make_sample($urandom(), $urandom(), $urandom(), sp);
		if (pick < 85) begin
			// tilted at rest, gravity near 16384 counts
			jx = int'($urandom_range(32768)) - 16384;
			jy = int'($urandom_range(32768)) - 16384;
			return make_sample(jx, jy, $urandom_range(16384), sp);
		end
		// return to rest, small x and y with z at 16384, after whatever came last
		return make_sample($urandom_range(200), $urandom_range(200), 16384, sp);
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_sample(random_sample());
	endtask

	task automatic test_reset_defaults();
		// first sample is swallowed by the reset hold-off, then zero-history case
		send_sample(make_sample(0, 0, 0, 0));
		send_sample(make_sample(0, 0, 0, 0));
		send_sample(make_sample(0, 0, 0, 0));
		// a big jump with default threshold zero
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 0));
	endtask

	task automatic test_extremes();
		write_reg(CFG_HOLDOFF, 0);
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 500));
		send_sample(make_sample(16'h7FFF, 16'h8000, 16'h7FFF, 501));
		send_sample(make_sample(16'h8000, 16'h7FFF, 0, 4095));
		send_sample(make_sample(0, 16'h7FFF, 0, 0));
		send_sample(make_sample(16'h7FFF, 0, 0, 0));
		send_sample(make_sample(0, 0, 16'h8000, 0));
		send_sample(make_sample(1, 16'hFFFF, 1, 500));
		send_sample(make_sample(16'h8000, 0, 0, 12));
		write_reg(CFG_ROLL_LIMIT, 255);
		send_sample(make_sample(0, 16'h7FFF, 0, 0));
		send_sample(make_sample(16'h8000, 16'h8000, 0, 0));
		write_reg(CFG_ROLL_LIMIT, 0);
		send_sample(make_sample(0, 1, 16'h7FFF, 0));
		send_sample(make_sample(0, 0, 16'h7FFF, 0));
		write_reg(CFG_INDEX_UNUSED, 17'h1FFFF);
		write_reg(CFG_THRESHOLD, 131071);
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 0));
	endtask

	task automatic test_holdoff();
		write_reg(CFG_THRESHOLD, 0);
		write_reg(CFG_HOLDOFF, 4);
		send_sample(make_sample(0, 0, 16384, 0));
		send_sample(make_sample(20000, 0, 16384, 0));
		for (int i = 0; i < 5; i++)
			send_sample(make_sample(i * 10, 0, 16384, 0));
		write_reg(CFG_HOLDOFF, 1);
		send_sample(make_sample(-20000, 3000, 0, 100));
		send_sample(make_sample(0, 0, 0, 100));
	endtask

	task automatic test_random_phase(int idle, int stall, longint unsigned thr,
			longint unsigned lim, longint unsigned reload, int n);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_ROLL_LIMIT, lim);
		write_reg(CFG_HOLDOFF, reload);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		run_random(n / 2);
		// let the pipeline run dry once mid-phase
		drain_results();
		run_random(n - n / 2);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_long_holdoff();
		write_reg(CFG_THRESHOLD, 0);
		write_reg(CFG_HOLDOFF, 255);
		send_idle_pct = 15;
		recv_stall_pct = 15;
		run_random(300);
	endtask

	// checker on every result transfer
	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result with nothing expected", $realtime);
				errors++;
			end else begin
				e = pending_verdicts.pop_front();
				verdicts_seen++;
				if (e.impact) impacts_seen++;
				if (e.rollover) rollovers_seen++;
				if (!e.evaluated) swallowed_seen++;
				if (evaluated !== e.evaluated) begin
					$display("%0t: evaluated exp %0d got %0d", $realtime, e.evaluated, evaluated);
					errors++;
				end
				if (crash_hit !== e.impact) begin
					$display("%0t: crash_hit exp %0d got %0d", $realtime, e.impact,
						crash_hit);
					errors++;
				end
				if (crash_mag !== e.magnitude) begin
					$display("%0t: crash_mag exp %0d got %0d", $realtime, e.magnitude,
						crash_mag);
					errors++;
				end
				if (roll_deg !== e.roll) begin
					$display("%0t: roll_deg exp %0d got %0d", $realtime, $signed(e.roll),
						$signed(roll_deg));
					errors++;
				end
				if (pitch_deg !== e.pitch) begin
					$display("%0t: pitch_deg exp %0d got %0d", $realtime, $signed(e.pitch),
						$signed(pitch_deg));
					errors++;
				end
				if (flip_hit !== e.rollover) begin
					$display("%0t: flip_hit exp %0d got %0d", $realtime, e.rollover,
						flip_hit);
					errors++;
				end
			end
		end
	end

	// receiver stall
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		speed_tenths_kmph = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_data = '0;
		errors = 0;
		samples_sent = 0;
		verdicts_seen = 0;
		impacts_seen = 0;
		rollovers_seen = 0;
		swallowed_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		thr_q = 0;
		lim_q = 45;
		reload_q = 75;
		last_x = 0;
		last_y = 0;
		last_z = 0;
		holdoff_q = 2;
		hist_ptr = 0;
		hist_sum = 0;
		for (int i = 0; i < RING_LEN; i++)
			mag_hist[i] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_extremes();
		test_holdoff();
		test_random_phase(0, 0, 0, 45, 3, 230);
		test_random_phase(83, 0, 200, 0, 1, 230);
		test_random_phase(0, 83, 131071, 180, 0, 230);
		test_random_phase(15, 15, 50, 30, 8, 230);
		test_long_holdoff();

		drain_results();
		repeat (100) @(posedge clk);
		$display("sent %0d samples, checked %0d results: %0d impacts, %0d rollovers, %0d held off",
			samples_sent, verdicts_seen, impacts_seen, rollovers_seen, swallowed_seen);
		$display("register extremes, idle and stall phases and a drained pipeline covered");
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("[accel_crash_rollover_detector_unit] OK");
		else
			$display("[accel_crash_rollover_detector_unit] ERROR");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl
rtl/acrd_pkg.sv
rtl/acrd_fifo.sv
rtl/acrd_front.sv
rtl/acrd_sqrt.sv
rtl/acrd_cordic.sv
rtl/acrd_back.sv
rtl/accel_crash_rollover_detector_unit.sv
rtl/acrd_checker.sv
tb/sv/accel_crash_rollover_detector_unit_tb.sv
